// File: rtl/cable_length_inverse_kinematics_macros.svh
// Assertion helpers shared by the checker files.
// Each macro samples on the rising edge of clk and is idle while rst is high.
`ifndef CABLE_LENGTH_INVERSE_KINEMATICS_MACROS_SVH
`define CABLE_LENGTH_INVERSE_KINEMATICS_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define CLIK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CLIK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/clik_pkg.sv
`timescale 1ns / 1ps

package clik_pkg;

  // Fixed field widths
  localparam int LEN_W      = 16;
  localparam int LIFT_W     = 3;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int RESULT_CAP = 8;

  // Input commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_LENGTH = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_LOADED = 2'd2
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_MIN_X    = 3'd0,
    CFG_BOX_MAX_X    = 3'd1,
    CFG_BOX_MIN_Y    = 3'd2,
    CFG_BOX_MAX_Y    = 3'd3,
    CFG_BOX_MIN_Z    = 3'd4,
    CFG_BOX_MAX_Z    = 3'd5,
    CFG_LIFTS_IN_USE = 3'd6
  } cfg_index_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOX,
    ST_READ,
    ST_DIFF,
    ST_SQUARE,
    ST_ROOT,
    ST_CHECK,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/cable_length_inverse_kinematics.sv
`timescale 1ns / 1ps

// Cable length solver for a cable-driven parallel robot. A load beat (cmd 0)
// writes one anchor entry (base point, zero length, end length). Its "loaded"
// result is loaded into the output register in the EMIT state, and the
// next beat can be taken back in IDLE. A move beat (cmd 1) checks the
// target against the configured box, then for each of the first lifts_in_use
// entries squares the three axis offsets on one shared multiplier and takes
// floor(sqrt) with a restoring root unit that resolves one bit per cycle.
// Each lift goes through read, offset, four multiply and accumulate steps,
// COORD_BITS + 1 root steps and a range check. Once every lift is done, the
// results go out one per cycle while the result side is ready, and the next
// beat is taken once the last of them is in the output register. A lift count
// of zero acts as one and larger counts are capped at the smaller of
// MAX_LIFTS and RESULT_CAP. A failed box or length check ends the move with
// one rejected result. in_ready is high only between items; a result may
// sit in the output register while the next beat is taken. Moves must only
// use entries that were loaded before. Configuration writes are taken at
// any time but belong to idle periods.
module cable_length_inverse_kinematics #(
  parameter int MAX_LIFTS  = 8,
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  cmd,
  input  logic [clik_pkg::LIFT_W-1:0]           lift_index,
  input  logic signed [COORD_BITS-1:0]          pos_x,
  input  logic signed [COORD_BITS-1:0]          pos_y,
  input  logic signed [COORD_BITS-1:0]          pos_z,
  input  logic [clik_pkg::LEN_W-1:0]            zero_length,
  input  logic [clik_pkg::LEN_W-1:0]            end_length,
  // Result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            status,
  output logic [clik_pkg::LIFT_W-1:0]           lift_number,
  output logic [clik_pkg::LEN_W-1:0]            cable_command,
  output logic                                  last,
  // Configuration channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [clik_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [COORD_BITS-1:0]                 cfg_data
);
  import clik_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int DW   = C;                       // magnitude of one offset
  localparam int SQW  = 2 * C;                   // one square
  localparam int RW   = C + 1;                   // root width
  localparam int SW   = 2 * RW;                  // sum of three squares
  localparam int IW   = $clog2(RW);
  localparam int CW   = (RW > LEN_W) ? RW : LEN_W;
  localparam int AW   = (MAX_LIFTS > 1) ? $clog2(MAX_LIFTS) : 1;
  localparam int NCAP = (MAX_LIFTS < RESULT_CAP) ? MAX_LIFTS : RESULT_CAP;

  typedef struct packed {
    logic signed [C-1:0] x;
    logic signed [C-1:0] y;
    logic signed [C-1:0] z;
    logic [LEN_W-1:0]    zero_len;
    logic [LEN_W-1:0]    end_len;
  } anchor_t;

  // Control
  state_t state;
  state_t state_next;

  // Configuration registers
  logic signed [C-1:0] box_lo [3];
  logic signed [C-1:0] box_hi [3];
  logic [COUNT_W-1:0]  lifts_in_use;

  // Anchor table
  anchor_t anchors [MAX_LIFTS];
  anchor_t anchor_rd;

  // Item registers
  logic signed [C-1:0] tgt [3];
  logic [LIFT_W-1:0]   load_idx;
  status_t             kind;
  logic [LIFT_W-1:0]   lift;
  logic [LIFT_W-1:0]   lift_last;

  // Arithmetic
  logic [DW-1:0]       ad [3];
  logic [1:0]          axis;
  logic [SQW-1:0]      sq;
  logic [SW-1:0]       acc;
  logic [RW+1:0]       rem;
  logic [RW-1:0]       root;
  logic [IW-1:0]       iter;
  logic [LEN_W-1:0]    lens [RESULT_CAP];

  // Combinational helpers
  logic                in_fire;
  logic                out_free;
  logic                box_fail;
  logic [COUNT_W-1:0]  n_eff;
  logic [DW-1:0]       mul_op;
  logic [RW+1:0]       rem_sh;
  logic [RW+1:0]       trial;
  logic [CW-1:0]       root_c;
  logic [CW-1:0]       zero_c;
  logic [CW-1:0]       end_c;
  logic                len_ok;
  logic signed [C:0]   dv [3];
  logic [C:0]          dabs [3];
  logic signed [C-1:0] base [3];

  assign in_ready  = (state == ST_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Box test and effective lift count
  always_comb begin
    box_fail = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (tgt[a] < box_lo[a] || tgt[a] > box_hi[a]) begin
        box_fail = 1'b1;
      end
    end
    if (lifts_in_use == '0) begin
      n_eff = COUNT_W'(1);
    end else if (lifts_in_use > COUNT_W'(NCAP)) begin
      n_eff = COUNT_W'(NCAP);
    end else begin
      n_eff = lifts_in_use;
    end
  end

  // Axis offsets and their magnitudes
  assign base[0] = anchor_rd.x;
  assign base[1] = anchor_rd.y;
  assign base[2] = anchor_rd.z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dv[a]   = {tgt[a][C-1], tgt[a]} - {base[a][C-1], base[a]};
      dabs[a] = dv[a][C] ? (~dv[a] + 1'b1) : dv[a];
    end
  end

  // Select the multiplier operand
  always_comb begin
    case (axis)
      2'd0:    mul_op = ad[0];
      2'd1:    mul_op = ad[1];
      2'd2:    mul_op = ad[2];
      default: mul_op = '0;
    endcase
  end

  // One restoring root step
  assign rem_sh = {rem[RW-1:0], acc[SW-1:SW-2]};
  assign trial  = {root, 2'b01};

  // Length range check
  assign root_c = CW'(root);
  assign zero_c = CW'(anchor_rd.zero_len);
  assign end_c  = CW'(anchor_rd.end_len);
  assign len_ok = (root_c >= zero_c) && (root_c <= end_c);

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = (cmd == CMD_LOAD) ? ST_EMIT : ST_BOX;
        end
      end
      ST_BOX:    state_next = box_fail ? ST_EMIT : ST_READ;
      ST_READ:   state_next = ST_DIFF;
      ST_DIFF:   state_next = ST_SQUARE;
      ST_SQUARE: begin
        if (axis == 2'd3) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (iter == IW'(RW - 1)) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!len_ok || lift == lift_last) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_EMIT: begin
        if (out_free && (kind != STATUS_LENGTH || lift == lift_last)) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        box_lo[a] <= {1'b1, {(C-1){1'b0}}};
        box_hi[a] <= {1'b0, {(C-1){1'b1}}};
      end
      lifts_in_use <= COUNT_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BOX_MIN_X:    box_lo[0] <= cfg_data;
        CFG_BOX_MAX_X:    box_hi[0] <= cfg_data;
        CFG_BOX_MIN_Y:    box_lo[1] <= cfg_data;
        CFG_BOX_MAX_Y:    box_hi[1] <= cfg_data;
        CFG_BOX_MIN_Z:    box_lo[2] <= cfg_data;
        CFG_BOX_MAX_Z:    box_hi[2] <= cfg_data;
        CFG_LIFTS_IN_USE: lifts_in_use <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Anchor table: write on load, registered read per lift
  always_ff @(posedge clk) begin
    if (in_fire && cmd == CMD_LOAD && int'(lift_index) < MAX_LIFTS) begin
      anchors[AW'(lift_index)] <= '{x: pos_x, y: pos_y, z: pos_z,
                                    zero_len: zero_length, end_len: end_length};
    end
    if (state == ST_READ) begin
      anchor_rd <= anchors[AW'(lift)];
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          tgt[0]   <= pos_x;
          tgt[1]   <= pos_y;
          tgt[2]   <= pos_z;
          load_idx <= lift_index;
          kind     <= STATUS_LOADED;
        end
      end
      ST_BOX: begin
        lift      <= '0;
        lift_last <= LIFT_W'(n_eff - COUNT_W'(1));
        if (box_fail) begin
          kind <= STATUS_REJECT;
        end
      end
      ST_DIFF: begin
        for (int a = 0; a < 3; a++) begin
          ad[a] <= dabs[a][DW-1:0];
        end
        axis <= '0;
      end
      ST_SQUARE: begin
        // square one axis while adding the previous square
        sq <= mul_op * mul_op;
        if (axis == 2'd0) begin
          acc <= '0;
        end else begin
          acc <= acc + SW'(sq);
        end
        axis <= axis + 2'd1;
        rem  <= '0;
        root <= '0;
        iter <= '0;
      end
      ST_ROOT: begin
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[RW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[RW-2:0], 1'b0};
        end
        acc  <= acc << 2;
        iter <= iter + IW'(1);
      end
      ST_CHECK: begin
        lens[lift] <= LEN_W'(root_c - zero_c);
        if (!len_ok) begin
          kind <= STATUS_REJECT;
        end else if (lift == lift_last) begin
          kind <= STATUS_LENGTH;
          lift <= '0;
        end else begin
          lift <= lift + LIFT_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_free && kind == STATUS_LENGTH) begin
          lift <= lift + LIFT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      status <= kind;
      case (kind)
        STATUS_LENGTH: begin
          lift_number   <= lift;
          cable_command <= lens[lift];
          last          <= (lift == lift_last);
        end
        STATUS_LOADED: begin
          lift_number   <= load_idx;
          cable_command <= '0;
          last          <= 1'b1;
        end
        default: begin
          lift_number   <= '0;
          cable_command <= '0;
          last          <= 1'b1;
        end
      endcase
    end
  end

endmodule

// File: rtl/clik_checker.sv
`timescale 1ns / 1ps
`include "cable_length_inverse_kinematics_macros.svh"

module clik_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   status,
  input logic [clik_pkg::LIFT_W-1:0]  lift_number,
  input logic [clik_pkg::LEN_W-1:0]   cable_command,
  input logic                         last
);
  import clik_pkg::*;

  // A stalled result beat holds
  `CLIK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(lift_number) && $stable(cable_command) && $stable(last), "result beat changed while stalled")

  // An accepted beat keeps the input closed in the cycle after it
  `CLIK_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken again right after a beat")

  // A rejected move is one beat with no lift and no length
  `CLIK_ASSERT_NOW(a_reject_shape, out_valid && status == STATUS_REJECT, last && lift_number == '0 && cable_command == '0, "malformed rejected result")

  // A load answer is a single beat with no length
  `CLIK_ASSERT_NOW(a_loaded_shape, out_valid && status == STATUS_LOADED, last && cable_command == '0, "malformed loaded result")

endmodule

bind cable_length_inverse_kinematics clik_checker u_clik_checker (.*);

// File: test/cable_length_inverse_kinematics_test.sv
`timescale 1ns / 1ps

import clik_pkg::*;

localparam int TABLE_DEPTH = 8;
localparam int STALL_LIMIT = 5000;

typedef struct {
  logic                    cmd;
  logic [LIFT_W-1:0]       lift_index;
  logic signed [15:0]      pos_x;
  logic signed [15:0]      pos_y;
  logic signed [15:0]      pos_z;
  logic [LEN_W-1:0]        zero_length;
  logic [LEN_W-1:0]        end_length;
} lift_item_t;

typedef struct {
  status_t                 status;
  logic [LIFT_W-1:0]       lift_number;
  logic [LEN_W-1:0]        cable_command;
  logic                    last;
} cable_result_t;

// Tracks the anchor table and box, predicts cable lengths and checks them in order.
class cable_length_board;
  int              box_lo[3];
  int              box_hi[3];
  logic [3:0]      lift_count;
  int              anchor[TABLE_DEPTH][3];
  int              zero_len[TABLE_DEPTH];
  int              end_len[TABLE_DEPTH];
  cable_result_t   pending_results[$];
  int              errors;

  function new();
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = -32768;
      box_hi[a] = 32767;
    end
    lift_count = 4'd3;
    errors = 0;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function void set_register(cfg_index_t idx, logic [15:0] data);
    case (idx)
      CFG_BOX_MIN_X:    box_lo[0] = $signed(data);
      CFG_BOX_MAX_X:    box_hi[0] = $signed(data);
      CFG_BOX_MIN_Y:    box_lo[1] = $signed(data);
      CFG_BOX_MAX_Y:    box_hi[1] = $signed(data);
      CFG_BOX_MIN_Z:    box_lo[2] = $signed(data);
      CFG_BOX_MAX_Z:    box_hi[2] = $signed(data);
      CFG_LIFTS_IN_USE: lift_count = data[3:0];
      default: ;
    endcase
  endfunction

  // Floor of the square root, one result bit at a time from the top.
  function longint unsigned int_root(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function void push(status_t st, int lift, logic [15:0] len, logic fin);
    cable_result_t res;
    res.status = st;
    res.lift_number = lift[LIFT_W-1:0];
    res.cable_command = len;
    res.last = fin;
    pending_results.push_back(res);
  endfunction

  // Work out the results of one accepted command.
  function void take_command(lift_item_t it);
    int              p[3];
    int              n;
    longint          d;
    longint          sq;
    longint          len;
    logic [15:0]     lens[TABLE_DEPTH];
    bit              ok;
    p[0] = it.pos_x;
    p[1] = it.pos_y;
    p[2] = it.pos_z;
    if (it.cmd == CMD_LOAD) begin
      for (int a = 0; a < 3; a++) anchor[it.lift_index][a] = p[a];
      zero_len[it.lift_index] = it.zero_length;
      end_len[it.lift_index] = it.end_length;
      push(STATUS_LOADED, it.lift_index, 16'd0, 1'b1);
      return;
    end
    // Clamp the lift count to one .. table depth
    n = lift_count;
    if (n == 0) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (p[a] < box_lo[a] || p[a] > box_hi[a]) ok = 1'b0;
    end
    for (int i = 0; i < n && ok; i++) begin
      sq = 0;
      for (int a = 0; a < 3; a++) begin
        d = longint'(p[a]) - longint'(anchor[i][a]);
        sq += d * d;
      end
      len = longint'(int_root(sq)) - zero_len[i];
      if (len < 0 || len > end_len[i] - zero_len[i]) ok = 1'b0;
      else lens[i] = len[15:0];
    end
    if (!ok) begin
      push(STATUS_REJECT, 0, 16'd0, 1'b1);
      return;
    end
    for (int i = 0; i < n; i++) push(STATUS_LENGTH, i, lens[i], i == n - 1);
  endfunction

  task flag_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task match_result(cable_result_t got);
    cable_result_t want;
    if (pending_results.size() == 0) begin
      flag_mismatch($sformatf("unexpected beat status %0d lift %0d length %0d last %0d",
                              got.status, got.lift_number, got.cable_command, got.last));
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status)
      flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.lift_number !== want.lift_number)
      flag_mismatch($sformatf("lift_number %0d, want %0d", got.lift_number,
                              want.lift_number));
    if (got.cable_command !== want.cable_command)
      flag_mismatch($sformatf("cable_command %0d, want %0d (lift %0d)", got.cable_command,
                              want.cable_command, want.lift_number));
    if (got.last !== want.last)
      flag_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
  endtask
endclass

module cable_length_inverse_kinematics_test;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     cmd = 1'b0;
  logic [LIFT_W-1:0]        lift_index = '0;
  logic signed [15:0]       pos_x = '0;
  logic signed [15:0]       pos_y = '0;
  logic signed [15:0]       pos_z = '0;
  logic [LEN_W-1:0]         zero_length = '0;
  logic [LEN_W-1:0]         end_length = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               status;
  logic [LIFT_W-1:0]        lift_number;
  logic [LEN_W-1:0]         cable_command;
  logic                     last;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [15:0]              cfg_data = '0;

  cable_length_board        board = new();
  cable_result_t            seen;
  int                       results_seen = 0;
  int                       stall_cycles = 0;
  bit                       quiet_in = 1'b0;

  cable_length_inverse_kinematics u_dut (.*);

  always #6 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic lift_item_t load_item(int idx, int x, int y, int z, int zl, int el);
    lift_item_t it;
    it.cmd = CMD_LOAD;
    it.lift_index = idx[LIFT_W-1:0];
    it.pos_x = x[15:0];
    it.pos_y = y[15:0];
    it.pos_z = z[15:0];
    it.zero_length = zl[15:0];
    it.end_length = el[15:0];
    return it;
  endfunction

  // Unused fields of a move carry random bits
  function automatic lift_item_t move_item(int x, int y, int z);
    lift_item_t it;
    it = load_item($urandom, x, y, z, $urandom, $urandom);
    it.cmd = CMD_MOVE;
    return it;
  endfunction

  function automatic int anchor_coord();
    return int'($urandom_range(0, 30000)) - 15000;
  endfunction

  // Target coordinate, mostly inside both the box and the anchor region
  function automatic int target_coord(int lo, int hi);
    int a;
    int b;
    a = (lo > -15000) ? lo : -15000;
    b = (hi < 15000) ? hi : 15000;
    if (a > b || $urandom_range(0, 99) < 8) return int'($urandom_range(0, 65535)) - 32768;
    return a + int'($urandom_range(0, b - a));
  endfunction

  // Offer one beat and hold it until accepted
  task automatic send(lift_item_t it);
    int gap;
    gap = pick_gap(quiet_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= it.cmd;
    lift_index <= it.lift_index;
    pos_x <= it.pos_x;
    pos_y <= it.pos_y;
    pos_z <= it.pos_z;
    zero_length <= it.zero_length;
    end_length <= it.end_length;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    board.take_command(it);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [15:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(idx, data);
    cfg_valid <= 1'b0;
    repeat ($urandom_range(1, 3)) @(posedge clk);
  endtask

  // Drop the input and wait until every expected beat has come out
  task automatic settle();
    if (board.pending() != 0) begin
      in_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clk);
    end
  endtask

  task automatic shape_axis(cfg_index_t lo_reg, cfg_index_t hi_reg);
    int lo;
    int hi;
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      lo = -int'($urandom_range(0, 20000));
      hi = $urandom_range(0, 20000);
    end else if (r < 85) begin
      lo = -32768;
      hi = 32767;
    end else begin
      lo = int'($urandom_range(0, 65535)) - 32768;
      hi = int'($urandom_range(0, 65535)) - 32768;
    end
    write_reg(lo_reg, lo[15:0]);
    write_reg(hi_reg, hi[15:0]);
  endtask

  task automatic full_box();
    write_reg(CFG_BOX_MIN_X, 16'h8000);
    write_reg(CFG_BOX_MAX_X, 16'h7fff);
    write_reg(CFG_BOX_MIN_Y, 16'h8000);
    write_reg(CFG_BOX_MAX_Y, 16'h7fff);
    write_reg(CFG_BOX_MIN_Z, 16'h8000);
    write_reg(CFG_BOX_MAX_Z, 16'h7fff);
  endtask

  // Main stimulus
  initial begin
    int r;
    int idx;
    int el;
    lift_item_t it;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the whole table first so no move reads an unwritten entry
    send(load_item(0, -32768, -32768, -32768, 0, 65535));
    send(load_item(1, 32767, 32767, 32767, 0, 65535));
    send(load_item(2, 0, 0, 0, 0, 65535));
    send(load_item(3, 1000, -2000, 3000, 100, 60000));
    send(load_item(4, -5000, 4000, 0, 0, 40000));
    send(load_item(5, 8000, 8000, -8000, 200, 50000));
    send(load_item(6, -12000, 0, 12000, 50, 65535));
    // end below zero: any move using this lift is rejected
    send(load_item(7, 0, 0, 0, 65535, 0));
    send(move_item(0, 0, 0));
    // corners: a cable longer than its travel
    send(move_item(32767, 32767, 32767));
    send(move_item(-32768, -32768, -32768));
    settle();
    write_reg(CFG_LIFTS_IN_USE, 16'd8);
    send(move_item(100, 200, 300));
    send(load_item(7, 20000, -20000, 20000, 0, 65535));
    send(move_item(100, 200, 300));
    // zero lifts acts as one, an oversized count saturates
    settle();
    write_reg(CFG_LIFTS_IN_USE, 16'd0);
    send(move_item(-300, 700, 50));
    settle();
    write_reg(CFG_LIFTS_IN_USE, 16'hfff);
    send(move_item(-300, 700, 50));
    // single point box on x, then its neighbors
    settle();
    write_reg(CFG_LIFTS_IN_USE, 16'd3);
    write_reg(CFG_BOX_MIN_X, 16'd5);
    write_reg(CFG_BOX_MAX_X, 16'd5);
    send(move_item(5, 0, 0));
    send(move_item(6, 0, 0));
    send(move_item(4, 0, 0));
    // inverted box
    settle();
    write_reg(CFG_BOX_MIN_X, 16'd100);
    write_reg(CFG_BOX_MAX_X, -16'sd100);
    send(move_item(0, 0, 0));
    settle();
    write_reg(CFG_BOX_MIN_X, 16'h8000);
    write_reg(CFG_BOX_MAX_X, 16'h7fff);
    write_reg(CFG_BOX_MIN_Y, -16'sd1000);
    write_reg(CFG_BOX_MAX_Y, 16'd1000);
    write_reg(CFG_BOX_MIN_Z, -16'sd1000);
    write_reg(CFG_BOX_MAX_Z, 16'd1000);
    send(move_item(0, 1001, 0));
    send(move_item(0, 0, -1001));
    send(move_item(0, 1000, -1000));

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      if (ph == 0) begin
        full_box();
        write_reg(CFG_LIFTS_IN_USE, 16'd8);
      end else begin
        shape_axis(CFG_BOX_MIN_X, CFG_BOX_MAX_X);
        shape_axis(CFG_BOX_MIN_Y, CFG_BOX_MAX_Y);
        shape_axis(CFG_BOX_MIN_Z, CFG_BOX_MAX_Z);
        if (ph == 5) write_reg(CFG_LIFTS_IN_USE, 16'd1);
        else write_reg(CFG_LIFTS_IN_USE, {12'($urandom_range(0, 4095)),
                                          4'($urandom_range(0, 15))});
      end
      quiet_in = (ph == 3);
      repeat (32) begin
        r = $urandom_range(0, 99);
        if (r < 25) begin
          idx = $urandom_range(0, TABLE_DEPTH - 1);
          el = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(60000, 65535);
          it = load_item(idx, anchor_coord(), anchor_coord(), anchor_coord(),
                         $urandom_range(0, 1500), el);
        end else if (r < 92) begin
          it = move_item(target_coord(board.box_lo[0], board.box_hi[0]),
                         target_coord(board.box_lo[1], board.box_hi[1]),
                         target_coord(board.box_lo[2], board.box_hi[2]));
        end else begin
          it = move_item($urandom, $urandom, $urandom);
          it.cmd = 1'($urandom_range(0, 1));
        end
        send(it);
      end
    end
    quiet_in = 1'b0;

    // Drain and give the block time to show any stray beat
    settle();
    repeat (250) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("cable_length_inverse_kinematics regression: pass");
    end else begin
      $display("cable_length_inverse_kinematics regression: fail");
    end
    $finish;
  end

  // Result side ready pattern, with one long hold-off to back the block up
  initial begin : result_sink
    int hold;
    int run;
    bit pressed;
    pressed = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!pressed && results_seen >= 120) begin
        pressed = 1'b1;
        out_ready <= 1'b0;
        repeat (700) @(posedge clk);
      end
      hold = pick_gap(1'b0);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
    end
  end

  // Check each result beat
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen.status = status_t'(status);
      seen.lift_number = lift_number;
      seen.cable_command = cable_command;
      seen.last = last;
      board.match_result(seen);
      results_seen <= results_seen + 1;
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("cable_length_inverse_kinematics regression: fail");
        $finish;
      end
    end
  end

endmodule

// File: cable_length_inverse_kinematics.f
+incdir+rtl
rtl/clik_pkg.sv
rtl/cable_length_inverse_kinematics.sv
rtl/clik_checker.sv
test/cable_length_inverse_kinematics_test.sv
